// ===== rtl/can_fast_packet_reassembler_defines.svh =====
// assertion macros for the fast-packet reassembler checker
`ifndef CAN_FAST_PACKET_REASSEMBLER_DEFINES_SVH
`define CAN_FAST_PACKET_REASSEMBLER_DEFINES_SVH

// same-cycle implication, clocked on aclk, off during reset
`define CFPR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on aclk, off during reset
`define CFPR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/cfpr_pkg.sv =====
// types, codes and the fast-packet group list for the reassembler
package cfpr_pkg;

    typedef struct packed {
        logic        mode;
        logic [16:0] group_number;
        logic [3:0]  frame_len;
        logic [63:0] frame_bytes;
        logic [7:0]  ninth_byte;
        logic [7:0]  read_index;
    } in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [16:0] message_group;
        logic [7:0]  message_len;
        logic [7:0]  read_byte;
        logic [31:0] msgs_done;
        logic [31:0] seq_errors;
        logic [31:0] abandoned;
        logic [31:0] frames_seen;
    } out_t;

    localparam logic [1:0] ST_COMPLETE   = 2'd0;
    localparam logic [1:0] ST_ERROR      = 2'd1;
    localparam logic [1:0] ST_INCOMPLETE = 2'd2;

    localparam logic [3:0] FAST_LEN = 4'd9;
    localparam logic [7:0] SEQ_MASK = 8'h1f;

    localparam int FAST_GROUP_COUNT = 17;

    // some entries exceed 17 bits and can never match
    localparam logic [18:0] FAST_GROUPS [FAST_GROUP_COUNT] = '{
        19'd126464, 19'd126996, 19'd127489, 19'd128275, 19'd129540, 19'd129542,
        19'd129793, 19'd129794, 19'd129798, 19'd129802, 19'd129809, 19'd129810,
        19'd130935, 19'd130842, 19'd262161, 19'd262384, 19'd262386
    };

    function automatic logic is_fast_group(input logic [16:0] grp);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < FAST_GROUP_COUNT; i++) begin
            if ({2'b00, grp} == FAST_GROUPS[i]) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

// ===== rtl/cfpr_ram.sv =====
// generic single-write, single-read ram with registered read data
module cfpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/can_fast_packet_reassembler.sv =====
// Fast-packet reassembler: one frame (or one buffer read) per beat, one result beat per input
// beat. The block takes a beat only when idle (s_ready high) and then works on it alone. The
// result of a mode-1 buffer read is registered out of the finish state after the decode and
// read states, and the next input beat can be taken in that same cycle. A frame takes one store
// step per slot of the single byte-wide write port of the payload buffer: 6 slots for a start
// frame, always 7 for a continuation frame (whether or not a byte is written there), frame_len
// slots for a single frame (up to 15), then a wrap-up step. An out-of-sequence frame has no
// slots and skips the wrap-up step. A result waiting for m_ready does not hold off the next
// input beat; the one after that waits until the result register frees up. Buffer positions
// wrap modulo BUFFER_DEPTH; reading a position never written returns an undefined byte.
module can_fast_packet_reassembler #(
    parameter int BUFFER_DEPTH = 256
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  cfpr_pkg::in_t s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output cfpr_pkg::out_t m_data
);

    import cfpr_pkg::*;

    localparam int AW = $clog2(BUFFER_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_READ,
        S_STORE,
        S_WRAP,
        S_FINISH
    } state_t;

    typedef enum logic [1:0] {
        K_START,
        K_MATCH,
        K_SINGLE
    } kind_t;

    state_t      state_reg, state_next;
    kind_t       kind_reg, kind_next;
    in_t         in_reg, in_next;
    logic [15:0] exp_idx_reg, exp_idx_next;
    logic [7:0]  wp_reg, wp_next;
    logic [7:0]  exp_len_reg, exp_len_next;
    logic [7:0]  asm_len_reg, asm_len_next;
    logic [16:0] done_group_reg, done_group_next;
    logic [1:0]  status_reg, status_next;
    logic [31:0] pkt_reg, pkt_next;
    logic [31:0] err_reg, err_next;
    logic [31:0] cnc_reg, cnc_next;
    logic [31:0] frm_reg, frm_next;
    logic [3:0]  byte_idx_reg, byte_idx_next;
    logic [3:0]  last_idx_reg, last_idx_next;
    logic [7:0]  rd_reg, rd_next;
    logic        m_valid_reg, m_valid_next;
    out_t        m_data_reg, m_data_next;

    logic        ram_we;
    logic [7:0]  ram_rdata;
    logic [7:0]  cur_byte;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic        fast_hit;
    logic        cancel_hit;

    assign b0         = in_reg.frame_bytes[7:0];
    assign b1         = in_reg.frame_bytes[15:8];
    assign fast_hit   = is_fast_group(in_reg.group_number) && (in_reg.frame_len == FAST_LEN);
    assign cancel_hit = (done_group_reg == 17'd0) && (status_reg == ST_INCOMPLETE);

    always_comb begin
        case (byte_idx_reg)
            4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7: begin
                cur_byte = in_reg.frame_bytes[{byte_idx_reg[2:0], 3'b000} +: 8];
            end
            4'd8: begin
                cur_byte = in_reg.ninth_byte;
            end
            default: begin
                cur_byte = 8'd0;
            end
        endcase
    end

    assign ram_we = (state_reg == S_STORE) && ((kind_reg != K_MATCH) || (exp_len_reg > wp_reg));

    cfpr_ram #(
        .WIDTH(8),
        .DEPTH(BUFFER_DEPTH)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(AW'(wp_reg)),
        .wdata(cur_byte),
        .raddr(AW'(in_reg.read_index)),
        .rdata(ram_rdata)
    );

    always_comb begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        in_next         = in_reg;
        exp_idx_next    = exp_idx_reg;
        wp_next         = wp_reg;
        exp_len_next    = exp_len_reg;
        asm_len_next    = asm_len_reg;
        done_group_next = done_group_reg;
        status_next     = status_reg;
        pkt_next        = pkt_reg;
        err_next        = err_reg;
        cnc_next        = cnc_reg;
        frm_next        = frm_reg;
        byte_idx_next   = byte_idx_reg;
        last_idx_next   = last_idx_reg;
        rd_next         = rd_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    in_next    = s_data;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                rd_next = 8'd0;
                if (in_reg.mode) begin
                    state_next = S_READ;
                end else if (fast_hit) begin
                    if ((b0 & SEQ_MASK) == 8'd0) begin
                        if (cancel_hit) begin
                            cnc_next = cnc_reg + 32'd1;
                        end
                        exp_len_next    = b1;
                        exp_idx_next    = 16'({8'd0, b0} + 16'd1);
                        wp_next         = 8'd0;
                        done_group_next = 17'd0;
                        status_next     = ST_INCOMPLETE;
                        byte_idx_next   = 4'd2;
                        last_idx_next   = 4'd7;
                        kind_next       = K_START;
                        state_next      = S_STORE;
                    end else if ({8'd0, b0} == exp_idx_reg) begin
                        status_next   = ST_INCOMPLETE;
                        byte_idx_next = 4'd1;
                        last_idx_next = 4'd7;
                        kind_next     = K_MATCH;
                        state_next    = S_STORE;
                    end else begin
                        exp_idx_next = 16'd0;
                        exp_len_next = 8'd0;
                        status_next  = ST_ERROR;
                        err_next     = err_reg + 32'd1;
                        frm_next     = frm_reg + 32'd1;
                        state_next   = S_FINISH;
                    end
                end else begin
                    if (cancel_hit) begin
                        cnc_next = cnc_reg + 32'd1;
                    end
                    wp_next       = 8'd0;
                    byte_idx_next = 4'd0;
                    last_idx_next = 4'(in_reg.frame_len - 4'd1);
                    kind_next     = K_SINGLE;
                    state_next    = (in_reg.frame_len == 4'd0) ? S_WRAP : S_STORE;
                end
            end
            S_READ: begin
                rd_next    = ram_rdata;
                state_next = S_FINISH;
            end
            S_STORE: begin
                if (ram_we) begin
                    wp_next = 8'(wp_reg + 8'd1);
                end
                byte_idx_next = 4'(byte_idx_reg + 4'd1);
                if (byte_idx_reg == last_idx_reg) begin
                    state_next = S_WRAP;
                end
            end
            S_WRAP: begin
                frm_next   = frm_reg + 32'd1;
                state_next = S_FINISH;
                case (kind_reg)
                    K_MATCH: begin
                        if (wp_reg == exp_len_reg) begin
                            asm_len_next    = exp_len_reg;
                            exp_len_next    = 8'd0;
                            done_group_next = in_reg.group_number;
                            status_next     = ST_COMPLETE;
                            pkt_next        = pkt_reg + 32'd1;
                        end else begin
                            exp_idx_next = 16'(exp_idx_reg + 16'd1);
                        end
                    end
                    K_SINGLE: begin
                        exp_idx_next    = 16'd0;
                        asm_len_next    = {4'd0, in_reg.frame_len};
                        exp_len_next    = 8'd0;
                        done_group_next = in_reg.group_number;
                        status_next     = ST_COMPLETE;
                        pkt_next        = pkt_reg + 32'd1;
                    end
                    default: begin
                    end
                endcase
            end
            S_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{
                        status:        status_reg,
                        message_group: done_group_reg,
                        message_len:   asm_len_reg,
                        read_byte:     rd_reg,
                        msgs_done:     pkt_reg,
                        seq_errors:    err_reg,
                        abandoned:     cnc_reg,
                        frames_seen:   frm_reg
                    };
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            exp_idx_reg    <= 16'd0;
            wp_reg         <= 8'd0;
            exp_len_reg    <= 8'd0;
            asm_len_reg    <= 8'd0;
            done_group_reg <= 17'd0;
            status_reg     <= ST_COMPLETE;
            pkt_reg        <= 32'd0;
            err_reg        <= 32'd0;
            cnc_reg        <= 32'd0;
            frm_reg        <= 32'd0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            exp_idx_reg    <= exp_idx_next;
            wp_reg         <= wp_next;
            exp_len_reg    <= exp_len_next;
            asm_len_reg    <= asm_len_next;
            done_group_reg <= done_group_next;
            status_reg     <= status_next;
            pkt_reg        <= pkt_next;
            err_reg        <= err_next;
            cnc_reg        <= cnc_next;
            frm_reg        <= frm_next;
            m_valid_reg    <= m_valid_next;
        end
        kind_reg     <= kind_next;
        in_reg       <= in_next;
        byte_idx_reg <= byte_idx_next;
        last_idx_reg <= last_idx_next;
        rd_reg       <= rd_next;
        m_data_reg   <= m_data_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== rtl/cfpr_checker.sv =====
// port-level checks for the fast-packet reassembler, bound to the top level
`include "can_fast_packet_reassembler_defines.svh"

module cfpr_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input cfpr_pkg::in_t  s_data,
    input logic           m_valid,
    input logic           m_ready,
    input cfpr_pkg::out_t m_data
);

    import cfpr_pkg::*;

    logic        in_beat;
    logic        out_beat;
    logic [1:0]  pend_reg, pend_next;
    logic [31:0] last_frm_reg;
    logic        have_last_reg;

    assign in_beat      = s_valid && s_ready;
    assign out_beat     = m_valid && m_ready;

    always_comb begin
        pend_next = pend_reg;
        if (in_beat && !out_beat) begin
            pend_next = 2'(pend_reg + 2'd1);
        end else if (out_beat && !in_beat) begin
            pend_next = 2'(pend_reg - 2'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg      <= 2'd0;
            have_last_reg <= 1'b0;
        end else begin
            pend_reg <= pend_next;
            if (out_beat) begin
                have_last_reg <= 1'b1;
            end
        end
        if (out_beat) begin
            last_frm_reg <= m_data.frames_seen;
        end
    end

    `CFPR_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data), "result beat dropped or changed while stalled")
    `CFPR_ASSERT_NOW(a_no_extra_out, out_beat, pend_reg != 2'd0 || in_beat, "result beat without a pending input beat")
    `CFPR_ASSERT_NOW(a_in_depth, in_beat, pend_reg == 2'd0 || pend_reg == 2'd1, "input beat taken with two results owed")
    `CFPR_ASSERT_NOW(a_frame_step, out_beat && have_last_reg, m_data.frames_seen == last_frm_reg || m_data.frames_seen == 32'(last_frm_reg + 32'd1), "frame count jumped between result beats")

endmodule

bind can_fast_packet_reassembler cfpr_checker u_cfpr_checker (.*);

// ===== test/can_fast_packet_reassembler_tb.sv =====
// self-checking testbench for the fast-packet reassembler: directed frames, long and stalled transfers, random traffic
module can_fast_packet_reassembler_tb;
    import cfpr_pkg::*;

    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_BEATS = 75;
    localparam int REACHABLE_IDS = 14;

    // the last three entries do not fit in 17 bits
    localparam logic [31:0] FAST_IDS [17] = '{
        32'd126464, 32'd126996, 32'd127489, 32'd128275, 32'd129540, 32'd129542,
        32'd129793, 32'd129794, 32'd129798, 32'd129802, 32'd129809, 32'd129810,
        32'd130935, 32'd130842, 32'd262161, 32'd262384, 32'd262386
    };

    logic aclk = 1'b0;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_t s_data;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    can_fast_packet_reassembler dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data)
    );

    always #4 aclk = ~aclk;

    // reassembly state mirror
    logic [15:0] seq_expected;
    logic [7:0] fill_ptr;
    logic [7:0] target_len;
    logic [7:0] done_len;
    logic [16:0] done_grp;
    logic [1:0] asm_state;
    logic [7:0] payload [256];
    logic written [256];
    logic [31:0] tally_packets;
    logic [31:0] tally_errors;
    logic [31:0] tally_cancels;
    logic [31:0] tally_frames;

    out_t expected_results [$];
    out_t oldest;
    int unsigned fault_count = 0;
    int unsigned frames_sent = 0;
    int unsigned reads_sent = 0;
    int unsigned quiet_cycles = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_request = 0;
    int unsigned hold_left = 0;

    function automatic logic listed_group(logic [16:0] grp);
        for (int i = 0; i < 17; i++) begin
            if (FAST_IDS[i] == {15'd0, grp}) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic void store_next(logic [7:0] v);
        payload[fill_ptr] = v;
        written[fill_ptr] = 1'b1;
        fill_ptr = fill_ptr + 8'd1;
    endfunction

    function automatic void note_cancel();
        if (done_grp == '0 && asm_state == ST_INCOMPLETE) begin
            tally_cancels = tally_cancels + 32'd1;
        end
    endfunction

    function automatic out_t reassemble_frame(in_t f);
        out_t r;
        logic [7:0] b [9];
        logic [7:0] rd;
        for (int i = 0; i < 8; i++) begin
            b[i] = f.frame_bytes[8*i +: 8];
        end
        b[8] = f.ninth_byte;
        rd = '0;
        if (f.mode) begin
            rd = payload[f.read_index];
        end else if (listed_group(f.group_number) && f.frame_len == FAST_LEN) begin
            if ((b[0] & SEQ_MASK) == 8'h00) begin
                note_cancel();
                target_len = b[1];
                seq_expected = {8'h00, b[0]} + 16'd1;
                fill_ptr = '0;
                done_grp = '0;
                asm_state = ST_INCOMPLETE;
                for (int i = 2; i < 8; i++) begin
                    store_next(b[i]);
                end
            end else if ({8'h00, b[0]} == seq_expected) begin
                asm_state = ST_INCOMPLETE;
                for (int i = 1; i < 8; i++) begin
                    if (target_len > fill_ptr) begin
                        store_next(b[i]);
                    end
                end
                if (fill_ptr == target_len) begin
                    done_len = target_len;
                    target_len = '0;
                    done_grp = f.group_number;
                    asm_state = ST_COMPLETE;
                    tally_packets = tally_packets + 32'd1;
                end else begin
                    seq_expected = seq_expected + 16'd1;
                end
            end else begin
                seq_expected = '0;
                target_len = '0;
                asm_state = ST_ERROR;
                tally_errors = tally_errors + 32'd1;
            end
            tally_frames = tally_frames + 32'd1;
        end else begin
            note_cancel();
            fill_ptr = '0;
            for (int i = 0; i < f.frame_len; i++) begin
                if (i < 9) begin
                    store_next(b[i]);
                end else begin
                    store_next(8'h00);
                end
            end
            seq_expected = '0;
            done_len = {4'd0, f.frame_len};
            target_len = '0;
            done_grp = f.group_number;
            asm_state = ST_COMPLETE;
            tally_packets = tally_packets + 32'd1;
            tally_frames = tally_frames + 32'd1;
        end
        r.status = asm_state;
        r.message_group = done_grp;
        r.message_len = done_len;
        r.read_byte = rd;
        r.msgs_done = tally_packets;
        r.seq_errors = tally_errors;
        r.abandoned = tally_cancels;
        r.frames_seen = tally_frames;
        return r;
    endfunction

    function automatic in_t frame_item(logic [16:0] grp, logic [3:0] len, logic [63:0] data,
                                       logic [7:0] ninth);
        in_t it;
        it.mode = 1'b0;
        it.group_number = grp;
        it.frame_len = len;
        it.frame_bytes = data;
        it.ninth_byte = ninth;
        it.read_index = 8'($urandom);
        return it;
    endfunction

    function automatic in_t fast_item(logic [16:0] grp, logic [7:0] b0, logic [7:0] b1);
        logic [63:0] data;
        data = {$urandom, $urandom};
        data[7:0] = b0;
        data[15:8] = b1;
        return frame_item(grp, FAST_LEN, data, 8'($urandom));
    endfunction

    function automatic in_t read_item(logic [7:0] idx);
        in_t it;
        it.mode = 1'b1;
        it.group_number = 17'($urandom);
        it.frame_len = 4'($urandom);
        it.frame_bytes = {$urandom, $urandom};
        it.ninth_byte = 8'($urandom);
        it.read_index = idx;
        return it;
    endfunction

    function automatic logic [16:0] pick_fast_group();
        return FAST_IDS[$urandom_range(REACHABLE_IDS - 1)][16:0];
    endfunction

    function automatic logic [7:0] random_written_index();
        logic [7:0] idx;
        idx = 8'($urandom_range(255));
        while (!written[idx]) begin
            idx = idx + 8'd1;
        end
        return idx;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s expected %0h actual %0h", name, want, got);
            fault_count++;
        end
    endfunction

    task automatic send_beat(in_t item);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= item;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        expected_results.push_back(reassemble_frame(item));
        if (item.mode) begin
            reads_sent++;
        end else begin
            frames_sent++;
        end
    endtask

    task automatic wait_for_idle();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // start, continuations at the expected index, then an optional way of breaking it
    task automatic run_transfer(logic [7:0] total, int break_kind);
        logic [16:0] grp;
        logic [7:0] b0;
        int sent;
        int cap;
        grp = pick_fast_group();
        send_beat(fast_item(grp, {3'($urandom_range(7)), 5'd0}, total));
        if (break_kind != 0) begin
            cap = $urandom_range(3);
        end else if (total < 6) begin
            cap = 2;
        end else begin
            cap = 31;
        end
        sent = 0;
        while (asm_state == ST_INCOMPLETE && sent < cap) begin
            if ($urandom_range(99) < 12) begin
                send_beat(read_item(random_written_index()));
            end else begin
                if ($urandom_range(3) == 0) begin
                    grp = pick_fast_group();
                end
                send_beat(fast_item(grp, seq_expected[7:0], 8'($urandom)));
                sent++;
            end
        end
        case (break_kind)
            1: begin
                do begin
                    b0 = 8'($urandom);
                end while (b0[4:0] == 5'd0 || {8'h00, b0} == seq_expected);
                send_beat(fast_item(grp, b0, 8'($urandom)));
            end
            2: send_beat(fast_item(grp, {3'($urandom_range(7)), 5'd0}, 8'($urandom)));
            3: send_beat(frame_item(17'($urandom), 4'($urandom_range(8)), {$urandom, $urandom},
                                    8'($urandom)));
            default: ;
        endcase
    endtask

    function automatic logic [7:0] random_total();
        int r;
        r = $urandom_range(99);
        if (r < 8) begin
            return 8'($urandom_range(5));
        end else if (r < 93) begin
            return 8'($urandom_range(40, 6));
        end
        return 8'($urandom_range(223, 41));
    endfunction

    task automatic test_directed_cases();
        in_t it;
        it = frame_item(17'd0, 4'd0, 64'd0, 8'd0);
        it.read_index = 8'd0;
        send_beat(it);
        it = frame_item(17'h1ffff, 4'd15, '1, 8'hff);
        it.read_index = 8'hff;
        send_beat(it);
        send_beat(read_item(8'd0));
        send_beat(read_item(8'd14));
        send_beat(read_item(8'd8));
        // two-frame message, then its last sequence index again from another listed group
        send_beat(fast_item(17'd126464, 8'h40, 8'd13));
        send_beat(fast_item(17'd126464, 8'h41, 8'h5a));
        send_beat(fast_item(17'd126996, 8'h41, 8'ha5));
        send_beat(read_item(8'd12));
        // listed groups at other lengths, and an aliased group number
        send_beat(frame_item(17'd129540, 4'd8, {$urandom, $urandom}, 8'h3c));
        send_beat(frame_item(17'd129542, 4'd12, {$urandom, $urandom}, 8'hc3));
        send_beat(frame_item(17'(262161), FAST_LEN, 64'h0, 8'h77));
        // short expected length never completes, single frame abandons it
        send_beat(fast_item(17'd127489, 8'h00, 8'd3));
        send_beat(fast_item(17'd127489, 8'h01, 8'h11));
        send_beat(frame_item(17'd1234, 4'd4, {$urandom, $urandom}, 8'h00));
        // expected length of six completes with nothing appended
        send_beat(fast_item(17'd128275, 8'h20, 8'd6));
        send_beat(fast_item(17'd128275, 8'h21, 8'hee));
        // out of sequence
        send_beat(fast_item(17'd129793, 8'h05, 8'h00));
        send_beat(fast_item(17'd129794, 8'h60, 8'd20));
        send_beat(fast_item(17'd129794, 8'h63, 8'h00));
        // zero length start, then a restart that abandons it
        send_beat(fast_item(17'd130935, 8'he0, 8'd0));
        send_beat(fast_item(17'd130842, 8'h80, 8'd9));
        send_beat(fast_item(17'd130842, 8'h81, 8'hff));
        send_beat(read_item(8'd7));
    endtask

    task automatic test_long_transfer();
        logic [16:0] grp;
        grp = 17'd129810;
        send_beat(fast_item(grp, 8'he0, 8'd223));
        while (asm_state == ST_INCOMPLETE) begin
            send_beat(fast_item(grp, seq_expected[7:0], 8'($urandom)));
        end
        send_beat(read_item(8'd222));
        send_beat(read_item(8'd127));
        send_beat(read_item(8'd128));
        repeat (4) begin
            send_beat(read_item(random_written_index()));
        end
    endtask

    // receiver holds off while frames keep coming, so the input stalls
    task automatic test_input_backpressure();
        hold_request = HOLD_OFF_CYCLES;
        run_transfer(8'd48, 0);
        send_beat(read_item(random_written_index()));
        send_beat(frame_item(17'($urandom), 4'd9, {$urandom, $urandom}, 8'($urandom)));
        send_beat(read_item(random_written_index()));
    endtask

    task automatic test_random_traffic(int unsigned beats);
        int unsigned start_count;
        int r;
        start_count = frames_sent + reads_sent;
        while (frames_sent + reads_sent - start_count < beats) begin
            r = $urandom_range(99);
            if (r < 50) begin
                run_transfer(random_total(), 0);
            end else if (r < 62) begin
                run_transfer(random_total(), $urandom_range(3, 1));
            end else if (r < 74) begin
                send_beat(frame_item(($urandom_range(1) == 0) ? pick_fast_group() : 17'($urandom),
                                     4'($urandom), {$urandom, $urandom}, 8'($urandom)));
            end else if (r < 86) begin
                send_beat(read_item(random_written_index()));
            end else begin
                send_beat(fast_item(pick_fast_group(), 8'($urandom), 8'($urandom)));
            end
        end
    endtask

    always @(posedge aclk) begin
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end else if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result beat with no frame waiting for it");
                    fault_count++;
                end else begin
                    oldest = expected_results.pop_front();
                    check_field("status", oldest.status, m_data.status);
                    check_field("message_group", oldest.message_group, m_data.message_group);
                    check_field("message_len", oldest.message_len, m_data.message_len);
                    check_field("read_byte", oldest.read_byte, m_data.read_byte);
                    check_field("msgs_done", oldest.msgs_done, m_data.msgs_done);
                    check_field("seq_errors", oldest.seq_errors, m_data.seq_errors);
                    check_field("abandoned", oldest.abandoned, m_data.abandoned);
                    check_field("frames_seen", oldest.frames_seen, m_data.frames_seen);
                end
            end
        end
    end

    initial begin
        int unsigned send_mix [4];
        int unsigned recv_mix [4];
        send_mix = '{0, 87, 0, 27};
        recv_mix = '{0, 0, 87, 27};
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        seq_expected = '0;
        fill_ptr = '0;
        target_len = '0;
        done_len = '0;
        done_grp = '0;
        asm_state = ST_COMPLETE;
        tally_packets = '0;
        tally_errors = '0;
        tally_cancels = '0;
        tally_frames = '0;
        for (int i = 0; i < 256; i++) begin
            payload[i] = '0;
            written[i] = 1'b0;
        end
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_cases();
        wait_for_idle();
        test_long_transfer();
        wait_for_idle();
        test_input_backpressure();
        wait_for_idle();
        for (int p = 0; p < 4; p++) begin
            send_idle_pct = send_mix[p];
            recv_stall_pct = recv_mix[p];
            test_random_traffic(RANDOM_BEATS);
            wait_for_idle();
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("covered %0d frames and %0d buffer reads over four idle patterns and a hold-off",
                 frames_sent, reads_sent);
        $display("messages completed %0d, sequence errors %0d, transfers abandoned %0d",
                 tally_packets, tally_errors, tally_cancels);
        if (fault_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
